@@ hw/rtl/rpn_pkg.sv @@
// RPN calculator package: operation and error codes, sequencer states.
// No dependencies.
package rpn_pkg;
	typedef enum logic [2:0] {
		FN_PUSH = 3'd0, FN_POP = 3'd1, FN_ADD = 3'd2, FN_NEG = 3'd3,
		FN_MUL = 3'd4, FN_DIV = 3'd5, FN_CLR = 3'd6, FN_NOP = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		ERR_OK = 3'd0, ERR_POP = 3'd1, ERR_UNARY = 3'd2, ERR_BINARY = 3'd3,
		ERR_OVERFLOW = 3'd4, ERR_DIVZERO = 3'd5, ERR_FULL = 3'd6
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD1, ST_RD2, ST_EXEC, ST_MUL, ST_DIV, ST_WB, ST_OUT
	} state_t;

	localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

	// Apply sign to magnitude and saturate.
	function automatic logic [64:0] sign_sat(input logic [63:0] mag, input logic neg,
			input logic big);
		logic [64:0] r;
		if (neg) begin
			if (big || mag > Q_MIN) r = {1'b1, Q_MIN};
			else r = {1'b0, 64'd0 - mag};
		end else begin
			if (big || mag > Q_MAX) r = {1'b1, Q_MAX};
			else r = {1'b0, mag};
		end
		return r;
	endfunction
endpackage

@@ hw/rtl/rpn_divider.sv @@
// Restoring divider, one quotient bit per cycle: ({num,32'b0}) / den on magnitudes.
// Depends on rpn_pkg.
module rpn_divider
	import rpn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quo,
	output logic        big
);
	logic [95:0] n_q;
	logic [63:0] r_q;
	logic [63:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] rs;
	logic        take;

	assign rs = {r_q, n_q[95]};
	assign take = rs >= {1'b0, den_q};
	assign done = busy_q && cnt_q == 7'd0;

	// Shift in one numerator bit per cycle, subtract when it fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 7'd96;
		end else if (busy_q) begin
			if (cnt_q == 7'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= {num, 32'd0};
			r_q <= '0;
			den_q <= den;
			quo <= '0;
			big <= 1'b0;
		end else if (busy_q && cnt_q != 7'd0) begin
			n_q <= {n_q[94:0], 1'b0};
			r_q <= take ? 64'(rs - {1'b0, den_q}) : rs[63:0];
			if (quo[63]) big <= 1'b1;
			quo <= {quo[62:0], take};
		end
	end
endmodule

@@ hw/rtl/rpn_stack_calculator_unit.sv @@
// RPN stack calculator top level: stack memory, sequencer, arithmetic.
// Depends on rpn_pkg and rpn_divider.
//
// channel | direction | signals
// in      | input     | in_valid, in_stall, func, operand
// out     | output    | out_valid, out_stall, popped, status, depth
//
// Sequencer path per item: push, clear and no-op go from IDLE through RD1 to OUT;
// the others go through RD1, RD2 and EXEC. Given valid operands, negate and add then
// write back in WB, multiply runs MUL (four 32x32 partial products, one per cycle)
// before WB, divide runs DIV (bit-serial divider, 96 quotient bits). One item at a time.
// Reset clears pointer, error code and handshake; stack contents stay undefined.
// A stalled result holds its register; input is stalled until it is taken.
module rpn_stack_calculator_unit
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [63:0] operand,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] popped,
	output logic [2:0]  status,
	output logic [7:0]  depth
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int PW = $clog2(STACK_DEPTH + 1);

	logic [63:0] mem [STACK_DEPTH];
	logic [63:0] rdata_q;
	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0] wdata;
	logic        re;

	state_t state_q, state_d;
	func_t  fn_q;
	logic [63:0] x_q, t_q, res_q;
	logic [PW-1:0] sp_q;
	err_t   err_q;
	logic   ovf_q;
	logic [1:0] mstep_q;
	logic [127:0] acc_q;
	logic [63:0] ma_q, mb_q;
	logic   neg_q;

	logic div_start, div_done, div_big;
	logic [63:0] div_quo;
	logic [63:0] div_num, div_den;

	logic [31:0] pa, pb;
	logic [63:0] prod;
	logic [63:0] sum;
	logic [127:0] mul_full;
	logic [64:0] mul_sat, div_sat;

	// Stack memory, one write and one registered read port.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	rpn_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo), .big(div_big)
	);

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = state_q == ST_OUT;

	// Partial product, sum, saturated results and divider operands.
	always_comb begin
		pa = mstep_q[0] ? ma_q[63:32] : ma_q[31:0];
		pb = mstep_q[1] ? mb_q[63:32] : mb_q[31:0];
		prod = 64'(pa) * 64'(pb);
		sum = rdata_q + t_q;
		mul_full = acc_q + (128'(prod) << 64);
		mul_sat = sign_sat(mul_full[95:32], neg_q, |mul_full[127:96]);
		div_sat = sign_sat(div_quo, neg_q, div_big);
		div_num = rdata_q[63] ? 64'd0 - rdata_q : rdata_q;
		div_den = t_q[63] ? 64'd0 - t_q : t_q;
	end

	// Next state and memory access.
	always_comb begin
		state_d = state_q;
		we = 1'b0; waddr = '0; wdata = res_q;
		re = 1'b0; raddr = '0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_RD1;
			ST_RD1: begin
				state_d = ST_EXEC;
				if (fn_q == FN_PUSH) begin
					if (sp_q != PW'(STACK_DEPTH)) begin
						we = 1'b1; waddr = AW'(sp_q); wdata = x_q;
					end
					state_d = ST_OUT;
				end else if (fn_q inside {FN_POP, FN_NEG, FN_ADD, FN_MUL, FN_DIV}) begin
					if (sp_q != '0) begin
						re = 1'b1; raddr = AW'(sp_q - PW'(1));
					end
					state_d = ST_RD2;
				end else state_d = ST_OUT;
			end
			ST_RD2: begin
				if (sp_q >= PW'(2)) begin
					re = 1'b1; raddr = AW'(sp_q - PW'(2));
				end
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_OUT;
				if (fn_q == FN_MUL && sp_q >= PW'(2)) state_d = ST_MUL;
				if (fn_q == FN_DIV && sp_q >= PW'(2) && t_q != '0) begin
					state_d = ST_DIV; div_start = 1'b1;
				end
				if ((fn_q == FN_ADD && sp_q >= PW'(2)) || (fn_q == FN_NEG && sp_q != '0))
					state_d = ST_WB;
			end
			ST_MUL: if (mstep_q == 2'd3) state_d = ST_WB;
			ST_DIV: if (div_done) state_d = ST_WB;
			ST_WB: begin
				we = 1'b1;
				waddr = (fn_q == FN_NEG) ? AW'(sp_q - PW'(1)) : AW'(sp_q - PW'(2));
				state_d = ST_OUT;
			end
			ST_OUT: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Datapath and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			err_q <= ERR_OK;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) begin
					fn_q <= func_t'(func); x_q <= operand; popped <= '0;
					ovf_q <= 1'b0;
				end
				ST_RD1: begin
					case (fn_q)
						FN_PUSH: if (sp_q != PW'(STACK_DEPTH)) sp_q <= sp_q + PW'(1);
							else err_q <= ERR_FULL;
						FN_CLR: begin sp_q <= '0; err_q <= ERR_OK; end
						default: ;
					endcase
				end
				ST_RD2: t_q <= rdata_q;
				ST_EXEC: begin
					mstep_q <= '0; acc_q <= '0;
					neg_q <= t_q[63] ^ rdata_q[63];
					ma_q <= rdata_q[63] ? 64'd0 - rdata_q : rdata_q;
					mb_q <= t_q[63] ? 64'd0 - t_q : t_q;
					case (fn_q)
						FN_POP: if (sp_q == '0) err_q <= ERR_POP;
							else begin popped <= t_q; sp_q <= sp_q - PW'(1); end
						FN_NEG: if (sp_q == '0) err_q <= ERR_UNARY;
							else begin
								if (t_q == Q_MIN) begin res_q <= Q_MAX; ovf_q <= 1'b1; end
								else res_q <= 64'd0 - t_q;
							end
						FN_ADD, FN_MUL, FN_DIV:
							if (sp_q < PW'(2)) err_q <= ERR_BINARY;
							else if (fn_q == FN_DIV && t_q == '0) err_q <= ERR_DIVZERO;
							else if (fn_q == FN_ADD) begin
								if (rdata_q[63] == t_q[63] && sum[63] != rdata_q[63]) begin
									res_q <= rdata_q[63] ? Q_MIN : Q_MAX; ovf_q <= 1'b1;
								end else res_q <= sum;
							end
						default: ;
					endcase
				end
				ST_MUL: begin
					acc_q <= acc_q + (128'(prod) << (7'(mstep_q[0]) * 7'd32 +
						7'(mstep_q[1]) * 7'd32));
					mstep_q <= mstep_q + 2'd1;
				end
				ST_WB: begin
					if (fn_q != FN_NEG) sp_q <= sp_q - PW'(1);
					if (ovf_q) err_q <= ERR_OVERFLOW;
				end
				default: ;
			endcase
			if (state_q == ST_MUL && state_d == ST_WB) begin
				res_q <= mul_sat[63:0]; ovf_q <= mul_sat[64];
			end
			if (state_q == ST_DIV && div_done) begin
				res_q <= div_sat[63:0]; ovf_q <= div_sat[64];
			end
		end
	end

	assign status = err_q;
	assign depth = 8'(sp_q);

	// Results never appear while the divider is still at work.
	a_div_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> $past(state_q) != ST_DIV || $past(div_done))
		else $error("result before divide finished");
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= PW'(STACK_DEPTH)) else $error("stack pointer out of range");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
endmodule
